@@ src/dfd_pkg.sv @@
// ----------------------------------------------------------------------------
// dfd_pkg: shared types and constants of the delimited frame deframer
// Byte codes, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h02;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0f;
  localparam logic [BYTE_W-1:0] START_RESET = 8'h01;
  localparam logic [BYTE_W-1:0] END_RESET = 8'h03;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 1'b0,
    CFG_END_MARKER   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
  } cfg_regs_t;

  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] out_byte;
    logic              has_data;
    logic              frame_end;
  } result_t;

endpackage

@@ src/dfd_if.sv @@
// ----------------------------------------------------------------------------
// dfd_if: valid/ready channels of the deframer
// One interface for raw input bytes and one for decoded result items.
// ----------------------------------------------------------------------------
interface dfd_in_if
  import dfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dfd_out_if
  import dfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              has_data;
  logic              frame_end;

  modport source (output valid, output out_byte, output has_data, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input has_data, input frame_end,
                  output ready);
endinterface

@@ src/dfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dfd_cfg_regs: marker configuration registers
// Holds the start and end marker values written through the config port.
// ----------------------------------------------------------------------------
module dfd_cfg_regs
  import dfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output cfg_regs_t            cfg
);

  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= START_RESET;
      cfg_r.end_marker   <= END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_START_MARKER: cfg_r.start_marker <= cfg_wdata;
        CFG_END_MARKER:   cfg_r.end_marker   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/dfd_decode.sv @@
// ----------------------------------------------------------------------------
// dfd_decode: per-byte framing decision and framing state
// Decides drop or emit for one byte and updates in-frame and escape state.
// ----------------------------------------------------------------------------
module dfd_decode
  import dfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] byte_in,
  input  cfg_regs_t         cfg,
  output result_t           res
);

  logic in_frame_r, in_frame_nxt;
  logic esc_pend_r, esc_pend_nxt;
  logic is_end, is_start;

  assign is_end   = (byte_in == cfg.end_marker);
  assign is_start = (byte_in == cfg.start_marker);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_pend_nxt = esc_pend_r;
    res          = '0;
    priority if (!in_frame_r) begin
      // Hunting for the opening marker; nothing is emitted.
      if (is_start) begin
        in_frame_nxt = 1'b1;
        esc_pend_nxt = 1'b0;
      end
    end else if (esc_pend_r) begin
      // The escaped byte is always data, and may also close the frame.
      esc_pend_nxt  = 1'b0;
      res.emit      = 1'b1;
      res.has_data  = 1'b1;
      res.out_byte  = byte_in & NIBBLE_MASK;
      res.frame_end = is_end;
      if (is_end) begin
        in_frame_nxt = 1'b0;
      end
    end else if (is_end) begin
      in_frame_nxt  = 1'b0;
      res.emit      = 1'b1;
      res.frame_end = 1'b1;
    end else if (is_start) begin
      // A stray start marker inside a frame is dropped.
    end else if (byte_in == ESC_BYTE) begin
      esc_pend_nxt = 1'b1;
    end else begin
      res.emit     = 1'b1;
      res.has_data = 1'b1;
      res.out_byte = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_pend_r <= 1'b0;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      esc_pend_r <= esc_pend_nxt;
    end
  end

  a_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    esc_pend_r |-> in_frame_r)
    else $error("escape pending outside a frame");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.emit && res.frame_end |=> !in_frame_r && !esc_pend_r)
    else $error("frame end result did not close the frame");

  a_nodata_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit && !res.has_data |-> res.frame_end && (res.out_byte == '0))
    else $error("dataless result that is not a clean frame end");

endmodule

@@ src/delimited_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// delimited_frame_deframer: start/end marker deframer with escape byte
// Strips framing and escapes from a received byte stream.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register and its decoded
// result in the result register, which drives the output.
// Throughput: one byte per cycle unless the result register is stalled; the
// decode logic between the two registers is three byte compares and a small
// select; a byte with no result passes the input register during a stall.
// Reset (synchronous, rst_n low): both stages empty, no frame open, no
// escape pending, start marker 0x01 and end marker 0x03.
module delimited_frame_deframer
  import dfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  dfd_in_if.sink               in_ch,
  dfd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  cfg_regs_t         cfg;
  result_t           res;

  // Input register stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Result register stage.
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_has_data_r;
  logic              out_frame_end_r;

  logic              out_free;
  logic              s1_advance;
  logic              s1_fire;

  dfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dfd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .byte_in (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // The result register can take a new item when it is empty or is being
  // drained this cycle. An item that yields no result never needs it, so it
  // is allowed through regardless; this keeps the framing state moving.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = out_free || !res.emit;
  assign s1_fire    = s1_valid_r && s1_advance;

  // The input register accepts a byte when empty or when its item moves on.
  assign in_ch.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && res.emit) begin
      out_byte_r      <= res.out_byte;
      out_has_data_r  <= res.has_data;
      out_frame_end_r <= res.frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.has_data  = out_has_data_r;
  assign out_ch.frame_end = out_frame_end_r;

  // A held result must not be overwritten by a result-bearing item.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && s1_fire |-> !res.emit)
    else $error("result register overwritten while stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("empty input stage not ready");

  a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(s1_fire && res.emit))
    else $error("result appeared without a decoded item");

endmodule
